>>> sv/cc20_pkg.sv
// shared types, constants and helper functions for the chacha20 byte cipher
// used by the design modules of the block (not by cc20_checker), no dependencies
package cc20_pkg;

  localparam int NUM_WORDS     = 16;
  localparam int DOUBLE_ROUNDS = 10;
  localparam int ROUND_STEPS   = DOUBLE_ROUNDS * 2 * 4;
  localparam int CNT_W         = $clog2(ROUND_STEPS);
  localparam int POS_W         = 6;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;

  localparam logic [CFG_IDX_W-1:0] REG_KEY01   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY23   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY45   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY67   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE01 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE2  = 3'd5;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam logic [31:0] CTR_START = 32'd1;

  typedef logic [31:0] word_t;
  typedef logic [NUM_WORDS-1:0][31:0] state_t;

  // rotate amount follows the step inside a quarter round: 16, 12, 8, 7
  function automatic word_t qr_rotl(word_t v, logic [1:0] step);
    word_t r;
    case (step)
      2'd0:    r = {v[15:0], v[31:16]};
      2'd1:    r = {v[19:0], v[31:20]};
      2'd2:    r = {v[23:0], v[31:24]};
      default: r = {v[24:0], v[31:25]};
    endcase
    return r;
  endfunction

  function automatic state_t build_init(logic [63:0] key01, logic [63:0] key23,
                                        logic [63:0] key45, logic [63:0] key67,
                                        logic [63:0] nonce01, word_t nonce2,
                                        word_t ctr);
    state_t s;
    s[0]  = SIGMA0;
    s[1]  = SIGMA1;
    s[2]  = SIGMA2;
    s[3]  = SIGMA3;
    s[4]  = key01[31:0];
    s[5]  = key01[63:32];
    s[6]  = key23[31:0];
    s[7]  = key23[63:32];
    s[8]  = key45[31:0];
    s[9]  = key45[63:32];
    s[10] = key67[31:0];
    s[11] = key67[63:32];
    s[12] = ctr;
    s[13] = nonce01[31:0];
    s[14] = nonce01[63:32];
    s[15] = nonce2;
    return s;
  endfunction

endpackage

>>> sv/cc20_round_step.sv
// one add-xor-rotate step of four quarter rounds side by side
// column or diagonal lane mapping; uses cc20_pkg
module cc20_round_step (
  input  cc20_pkg::state_t w_in,
  input  logic [1:0]       step,
  input  logic             diag,
  output cc20_pkg::state_t w_out
);

  always_comb begin
    logic [1:0]       ln;
    logic [3:0]       ia, ib, ic, id, ix, iy, iz;
    cc20_pkg::word_t  sum;
    w_out = w_in;
    for (int i = 0; i < 4; i++) begin
      ln = 2'(i);
      ia = {2'b00, ln};
      ib = {2'b01, ln + {1'b0, diag}};
      ic = {2'b10, ln + {diag, 1'b0}};
      id = {2'b11, ln + {diag, diag}};
      if (!step[0]) begin
        ix = ia;
        iy = ib;
        iz = id;
      end else begin
        ix = ic;
        iy = id;
        iz = ib;
      end
      sum       = w_in[ix] + w_in[iy];
      w_out[ix] = sum;
      w_out[iz] = cc20_pkg::qr_rotl(w_in[iz] ^ sum, step);
    end
  end

endmodule

>>> sv/cc20_block_gen.sv
// keystream block generator: step sequencer, working state and feed-forward
// holds the current 64-byte keystream block; uses cc20_pkg and cc20_round_step
module cc20_block_gen (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  cc20_pkg::state_t            init,
  input  logic [cc20_pkg::POS_W-1:0]  ks_sel,
  output logic                        done,
  output logic [7:0]                  ks_byte
);

  localparam logic [1:0] G_IDLE  = 2'd0;
  localparam logic [1:0] G_ROUND = 2'd1;
  localparam logic [1:0] G_FINAL = 2'd2;

  localparam logic [cc20_pkg::CNT_W-1:0] CNT_LAST =
    cc20_pkg::CNT_W'(cc20_pkg::ROUND_STEPS - 1);

  logic [1:0]                  g_st_r, g_st_nxt;
  logic [cc20_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  cc20_pkg::state_t            w_r, w_step, ks_r;
  cc20_pkg::word_t             ks_word;

  cc20_round_step u_step (
    .w_in  (w_r),
    .step  (cnt_r[1:0]),
    .diag  (cnt_r[2]),
    .w_out (w_step)
  );

  always_comb begin
    g_st_nxt = g_st_r;
    cnt_nxt  = cnt_r;
    case (g_st_r)
      G_IDLE: begin
        if (start) begin
          g_st_nxt = G_ROUND;
          cnt_nxt  = '0;
        end
      end
      G_ROUND: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          g_st_nxt = G_FINAL;
        end
      end
      G_FINAL: g_st_nxt = G_IDLE;
      default: g_st_nxt = G_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_st_r <= G_IDLE;
      cnt_r  <= '0;
    end else begin
      g_st_r <= g_st_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && g_st_r == G_IDLE) begin
      w_r <= init;
    end else if (g_st_r == G_ROUND) begin
      w_r <= w_step;
    end
  end

  // feed-forward add
  always_ff @(posedge clk) begin
    if (g_st_r == G_FINAL) begin
      for (int i = 0; i < cc20_pkg::NUM_WORDS; i++) begin
        ks_r[i] <= w_r[i] + init[i];
      end
    end
  end

  assign done    = (g_st_r == G_FINAL);
  assign ks_word = ks_r[ks_sel[5:2]];
  assign ks_byte = 8'(ks_word >> {ks_sel[1:0], 3'b000});

endmodule

>>> sv/chacha20_stream_cipher.sv
// chacha20 byte stream cipher, top level: config registers, byte position,
// block counter, transfer handshakes; uses cc20_pkg and cc20_block_gen
//
// Each input byte is XORed with the next byte of the chacha20 keystream
// (20 rounds, 256-bit key, 96-bit nonce, 32-bit block counter starting at 1).
// A byte inside a keystream block goes from its input transfer straight into
// the output register. The first byte of each 64-byte block, and the first
// byte after a byte marked last, waits for the block: 80 steps of the shared
// four-lane quarter-round step unit, the feed-forward add and the load of the
// output register.
// The input is not ready while a block is computed. Key and nonce registers
// are read at each block boundary and should be written only while idle.
module chacha20_stream_cipher (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         in_data_byte,
  input  logic                               in_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         out_byte,
  output logic                               out_last,
  input  logic                               cfg_wr_en,
  input  logic [cc20_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cc20_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_GEN  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [63:0]                   key01_r, key23_r, key45_r, key67_r, nonce01_r;
  logic [31:0]                   nonce2_r;
  logic [1:0]                    st_r, st_nxt;
  logic [cc20_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic [31:0]                   ctr_r, ctr_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [7:0]                    out_byte_r, hold_data_r;
  logic                          out_last_r, hold_last_r;

  logic                          slot_free, accept, gen_start, gen_done;
  logic                          emit_direct, emit_hold, emit;
  logic [7:0]                    em_data, ks_byte;
  logic                          em_last;
  cc20_pkg::state_t              init;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key01_r   <= '0;
      key23_r   <= '0;
      key45_r   <= '0;
      key67_r   <= '0;
      nonce01_r <= '0;
      nonce2_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cc20_pkg::REG_KEY01:   key01_r   <= cfg_wdata;
        cc20_pkg::REG_KEY23:   key23_r   <= cfg_wdata;
        cc20_pkg::REG_KEY45:   key45_r   <= cfg_wdata;
        cc20_pkg::REG_KEY67:   key67_r   <= cfg_wdata;
        cc20_pkg::REG_NONCE01: nonce01_r <= cfg_wdata;
        cc20_pkg::REG_NONCE2:  nonce2_r  <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  assign init = cc20_pkg::build_init(key01_r, key23_r, key45_r, key67_r,
                                     nonce01_r, nonce2_r, ctr_r);

  cc20_block_gen u_gen (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (gen_start),
    .init    (init),
    .ks_sel  (pos_r),
    .done    (gen_done),
    .ks_byte (ks_byte)
  );

  assign slot_free   = !out_valid_r || out_ready;
  assign in_ready    = (st_r == ST_IDLE) && slot_free;
  assign accept      = in_valid && in_ready;
  assign gen_start   = accept && (pos_r == '0);
  assign emit_direct = accept && (pos_r != '0);
  assign emit_hold   = (st_r == ST_EMIT) && slot_free;
  assign emit        = emit_direct || emit_hold;
  assign em_data     = emit_hold ? hold_data_r : in_data_byte;
  assign em_last     = emit_hold ? hold_last_r : in_last;

  always_comb begin
    st_nxt        = st_r;
    pos_nxt       = pos_r;
    ctr_nxt       = ctr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (st_r)
      ST_IDLE: if (gen_start) st_nxt = ST_GEN;
      ST_GEN:  if (gen_done)  st_nxt = ST_EMIT;
      ST_EMIT: if (emit_hold) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
    if (emit) begin
      out_valid_nxt = 1'b1;
      if (em_last) begin
        pos_nxt = '0;
        ctr_nxt = cc20_pkg::CTR_START;
      end else begin
        pos_nxt = pos_r + 1'b1;
        if (pos_r == '1) begin
          ctr_nxt = ctr_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      pos_r       <= '0;
      ctr_r       <= cc20_pkg::CTR_START;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      pos_r       <= pos_nxt;
      ctr_r       <= ctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_start) begin
      hold_data_r <= in_data_byte;
      hold_last_r <= in_last;
    end
    if (emit) begin
      out_byte_r <= em_data ^ ks_byte;
      out_last_r <= em_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

>>> sv/cc20_checker.sv
// port-level checks for chacha20_stream_cipher, attached by bind
// depends only on the handshake and payload ports of the top level
module cc20_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic [7:0]                         in_data_byte,
  input logic                               in_last,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [7:0]                         out_byte,
  input logic                               out_last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("result changed while stalled");

  // waiting input transfer holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data_byte) && $stable(in_last))
    else $error("input changed while waiting");

  // no input transfer while the output register is full and stalled
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid || out_ready)
    else $error("input taken with output register blocked");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind chacha20_stream_cipher cc20_checker u_cc20_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_data_byte (in_data_byte),
  .in_last      (in_last),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_byte     (out_byte),
  .out_last     (out_last)
);

>>> tb/sv/chacha20_stream_cipher_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for chacha20_stream_cipher: byte transfers with random
// idling, key and nonce programming, and a keystream predictor; needs cc20_pkg
// and the rtl of the block, nothing else
module chacha20_stream_cipher_tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned DRAIN_WAIT  = 100;
  localparam int unsigned PHASE_ITEMS = 112;
  localparam int unsigned MAX_REPORTS = 10;

  localparam logic [cc20_pkg::CFG_IDX_W-1:0] REG_UNUSED6 = 3'd6;
  localparam logic [cc20_pkg::CFG_IDX_W-1:0] REG_UNUSED7 = 3'd7;

  typedef enum {KEYS_ZERO, KEYS_ONES, KEYS_RANDOM} key_pattern_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cipher_byte_t;

  class chacha_xor_checker;
    logic [63:0]  regs [6];
    logic [31:0]  ks_words [16];
    logic [31:0]  work [16];
    logic [5:0]   pos;
    logic [31:0]  block_ctr;
    cipher_byte_t expected_bytes [$];
    int unsigned  mismatches;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (ks_words[i]) ks_words[i] = '0;
      pos        = '0;
      block_ctr  = cc20_pkg::CTR_START;
      mismatches = 0;
    endfunction

    function void load_reg(logic [cc20_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
      case (idx)
        cc20_pkg::REG_KEY01:   regs[0] = val;
        cc20_pkg::REG_KEY23:   regs[1] = val;
        cc20_pkg::REG_KEY45:   regs[2] = val;
        cc20_pkg::REG_KEY67:   regs[3] = val;
        cc20_pkg::REG_NONCE01: regs[4] = val;
        cc20_pkg::REG_NONCE2:  regs[5] = {32'd0, val[31:0]};
        default: ;
      endcase
    endfunction

    function logic [31:0] rotl(logic [31:0] v, int unsigned n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void quarter(int a, int b, int c, int d);
      work[a] += work[b]; work[d] = rotl(work[d] ^ work[a], 16);
      work[c] += work[d]; work[b] = rotl(work[b] ^ work[c], 12);
      work[a] += work[b]; work[d] = rotl(work[d] ^ work[a], 8);
      work[c] += work[d]; work[b] = rotl(work[b] ^ work[c], 7);
    endfunction

    function void refill_keystream();
      logic [31:0] init_w [16];
      init_w[0] = cc20_pkg::SIGMA0;
      init_w[1] = cc20_pkg::SIGMA1;
      init_w[2] = cc20_pkg::SIGMA2;
      init_w[3] = cc20_pkg::SIGMA3;
      for (int i = 0; i < 4; i++) begin
        init_w[4 + 2 * i] = regs[i][31:0];
        init_w[5 + 2 * i] = regs[i][63:32];
      end
      init_w[12] = block_ctr;
      init_w[13] = regs[4][31:0];
      init_w[14] = regs[4][63:32];
      init_w[15] = regs[5][31:0];
      foreach (work[i]) work[i] = init_w[i];
      for (int r = 0; r < cc20_pkg::DOUBLE_ROUNDS; r++) begin
        quarter(0, 4, 8, 12);
        quarter(1, 5, 9, 13);
        quarter(2, 6, 10, 14);
        quarter(3, 7, 11, 15);
        quarter(0, 5, 10, 15);
        quarter(1, 6, 11, 12);
        quarter(2, 7, 8, 13);
        quarter(3, 4, 9, 14);
      end
      foreach (ks_words[i]) ks_words[i] = work[i] + init_w[i];
    endfunction

    function void note_byte_in(logic [7:0] data, logic last);
      logic [31:0]  word;
      cipher_byte_t exp_b;
      if (pos == 0) refill_keystream();
      word       = ks_words[pos[5:2]] >> (8 * pos[1:0]);
      exp_b.data = data ^ word[7:0];
      exp_b.last = last;
      expected_bytes.push_back(exp_b);
      if (last) begin
        pos       = '0;
        block_ctr = cc20_pkg::CTR_START;
      end else begin
        pos = pos + 6'd1;
        if (pos == 0) block_ctr = block_ctr + 32'd1;
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_byte_out(logic [7:0] data, logic last);
      cipher_byte_t exp_b;
      if (expected_bytes.size() == 0) begin
        flag($sformatf("unexpected output byte %02h last %0b", data, last));
        return;
      end
      exp_b = expected_bytes.pop_front();
      if (data !== exp_b.data)
        flag($sformatf("out_byte mismatch: expected %02h actual %02h", exp_b.data, data));
      if (last !== exp_b.last)
        flag($sformatf("out_last mismatch: expected %0b actual %0b", exp_b.last, last));
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic                            clk          = 1'b0;
  logic                            rst_n        = 1'b0;
  logic                            in_valid     = 1'b0;
  logic                            in_ready;
  logic [7:0]                      in_data_byte = '0;
  logic                            in_last      = 1'b0;
  logic                            out_valid;
  logic                            out_ready    = 1'b0;
  logic [7:0]                      out_byte;
  logic                            out_last;
  logic                            cfg_wr_en    = 1'b0;
  logic [cc20_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [cc20_pkg::CFG_DATA_W-1:0] cfg_wdata    = '0;

  int unsigned       send_idle_pct  = 0;
  int unsigned       recv_stall_pct = 0;
  bit                long_hold_req  = 1'b0;
  int unsigned       cycles         = 0;
  chacha_xor_checker xor_check      = new();

  chacha20_stream_cipher u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // transfer monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) xor_check.note_byte_in(in_data_byte, in_last);
      if (out_valid && out_ready) xor_check.check_byte_out(out_byte, out_last);
    end
  end

  // receiver with random stalls and an optional long hold
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic last);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    in_data_byte <= data;
    in_last      <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (xor_check.pending() != 0);
  endtask

  task automatic write_reg(input logic [cc20_pkg::CFG_IDX_W-1:0] idx,
                           input logic [63:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    xor_check.load_reg(idx, val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] pattern_value(key_pattern_t pat);
    case (pat)
      KEYS_ZERO: return '0;
      KEYS_ONES: return '1;
      default:   return {$urandom, $urandom};
    endcase
  endfunction

  task automatic program_regs(input key_pattern_t pat);
    write_reg(cc20_pkg::REG_KEY01, pattern_value(pat));
    write_reg(cc20_pkg::REG_KEY23, pattern_value(pat));
    write_reg(cc20_pkg::REG_KEY45, pattern_value(pat));
    write_reg(cc20_pkg::REG_KEY67, pattern_value(pat));
    write_reg(cc20_pkg::REG_NONCE01, pattern_value(pat));
    write_reg(cc20_pkg::REG_NONCE2, pattern_value(pat));
    // indexes past the last register must be ignored
    write_reg(REG_UNUSED6, {$urandom, $urandom});
    write_reg(REG_UNUSED7, {$urandom, $urandom});
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_byte(pick_byte(), i == len - 1);
  endtask

  task automatic send_random(input int unsigned budget);
    int unsigned sent;
    int unsigned len;
    int unsigned r;
    sent = 0;
    while (sent < budget) begin
      r = $urandom_range(99);
      if (r < 75) len = $urandom_range(1, 8);
      else if (r < 92) len = $urandom_range(9, 63);
      else len = $urandom_range(64, 135);
      if (len > budget - sent) len = budget - sent;
      send_message(len);
      sent += len;
    end
  endtask

  initial begin
    key_pattern_t phase_keys [4];
    int unsigned  idle_prof  [4];
    int unsigned  stall_prof [4];
    phase_keys = '{KEYS_RANDOM, KEYS_ZERO, KEYS_RANDOM, KEYS_ONES};
    idle_prof  = '{0, 52, 0, 19};
    stall_prof = '{0, 0, 52, 19};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset key and nonce, single-byte messages
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    // key change in the middle of a block keeps the old keystream
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'ha5, 1'b0);
    drain();
    write_reg(cc20_pkg::REG_KEY01, {$urandom, $urandom});
    write_reg(cc20_pkg::REG_NONCE2, {$urandom, $urandom});
    send_byte(8'h5a, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b1);
    // all-ones key and nonce, nonce word 2 written with upper bits set
    drain();
    program_regs(KEYS_ONES);
    send_byte(8'h7f, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b1);
    send_byte(8'hff, 1'b1);
    drain();
    program_regs(KEYS_ZERO);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b1);

    for (int p = 0; p < 4; p++) begin
      drain();
      send_idle_pct  = idle_prof[p];
      recv_stall_pct = stall_prof[p];
      program_regs(phase_keys[p]);
      if (p == 0) long_hold_req = 1'b1;
      send_random(PHASE_ITEMS);
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (xor_check.mismatches == 0 && xor_check.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
